/* sv/static_model_arithmetic_encoder_core_assert.svh */
`ifndef STATIC_MODEL_ARITHMETIC_ENCODER_CORE_ASSERT_SVH
`define STATIC_MODEL_ARITHMETIC_ENCODER_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst is high
`define SMAE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst is high
`define SMAE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/smae_pkg.sv */
package smae_pkg;

  // coding precision and model size
  localparam int PRECISION   = 16;
  localparam int ALPHABET    = 256;
  localparam int RUN_BITS    = 16;
  localparam int TABLE_DEPTH = ALPHABET + 1;

  // beat field widths
  localparam int ACTION_W = 2;
  localparam int SYMBOL_W = 8;
  localparam int INDEX_W  = 9;
  localparam int VALUE_W  = 17;
  localparam int RUN_W    = 16;
  localparam int STATUS_W = 2;

  // datapath widths
  localparam int RANGE_W = PRECISION;
  localparam int PROD_W  = RANGE_W + VALUE_W;
  localparam int ONES_W  = RUN_BITS;
  localparam int CNT_W   = $clog2(PRECISION + 1);

  localparam logic [INDEX_W-1:0] TABLE_LAST   = INDEX_W'(ALPHABET);
  localparam logic [INDEX_W-1:0] SYMBOL_LIMIT = INDEX_W'(ALPHABET);
  localparam logic [CNT_W-1:0]   FLUSH_COUNT  = CNT_W'(PRECISION);

  // actions
  localparam logic [ACTION_W-1:0] ACT_LOAD   = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_ENCODE = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_FLUSH  = 2'd2;

  // result status
  localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ZERO_WIDTH = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RUN_OVF    = 2'd2;

  // run packer commands
  localparam logic [1:0] OP_RUN    = 2'd0;
  localparam logic [1:0] OP_CLOSE  = 2'd1;
  localparam logic [1:0] OP_STATUS = 2'd2;

  typedef struct packed {
    logic                valid;
    logic [1:0]          op;
    logic                code_bit;
    logic [RUN_W-1:0]    count;
    logic [STATUS_W-1:0] status;
    logic                last;
  } pack_cmd_t;

  typedef struct packed {
    logic ready;
    logic acc_valid;
  } pack_stat_t;

endpackage

/* sv/smae_ifs.sv */
interface smae_in_if;
  logic                            valid;
  logic                            ready;
  logic [smae_pkg::ACTION_W-1:0]   action;
  logic [smae_pkg::SYMBOL_W-1:0]   symbol;
  logic [smae_pkg::INDEX_W-1:0]    table_index;
  logic [smae_pkg::VALUE_W-1:0]    table_value;

  modport source (output valid, action, symbol, table_index, table_value, input ready);
  modport sink (input valid, action, symbol, table_index, table_value, output ready);
endinterface

interface smae_out_if;
  logic                            valid;
  logic                            ready;
  logic                            code_bit;
  logic [smae_pkg::RUN_W-1:0]      run_length;
  logic [smae_pkg::STATUS_W-1:0]   status;
  logic                            last;

  modport source (output valid, code_bit, run_length, status, last, input ready);
  modport sink (input valid, code_bit, run_length, status, last, output ready);
endinterface

/* sv/smae_run_pack.sv */
`include "static_model_arithmetic_encoder_core_assert.svh"

module smae_run_pack (
  input  logic                   clk,
  input  logic                   rst,
  input  smae_pkg::pack_cmd_t    cmd,
  output smae_pkg::pack_stat_t   stat,
  smae_out_if.source             results
);

  logic                          acc_valid;
  logic                          acc_bit;
  logic [smae_pkg::RUN_W-1:0]    acc_run;

  logic                          o_valid;
  logic                          o_bit;
  logic [smae_pkg::RUN_W-1:0]    o_run;
  logic [smae_pkg::STATUS_W-1:0] o_status;
  logic                          o_last;

  logic                          out_free;
  logic [smae_pkg::RUN_W:0]      run_sum;
  logic                          run_zero;
  logic                          run_merge;
  logic                          fire;
  logic                          emit_acc;
  logic                          emit_status;

  always_comb begin
    out_free    = !o_valid || results.ready;
    run_sum     = {1'b0, acc_run} + {1'b0, cmd.count};
    run_zero    = (cmd.count == '0);
    run_merge   = acc_valid && (acc_bit == cmd.code_bit) && !run_sum[smae_pkg::RUN_W];
    stat.ready  = 1'b1;
    emit_acc    = 1'b0;
    emit_status = 1'b0;
    unique case (cmd.op)
      smae_pkg::OP_RUN: begin
        stat.ready = run_zero || run_merge || !acc_valid || out_free;
        emit_acc   = cmd.valid && !run_zero && !run_merge && acc_valid && out_free;
      end
      smae_pkg::OP_CLOSE: begin
        stat.ready = !acc_valid || out_free;
        emit_acc   = cmd.valid && acc_valid && out_free;
      end
      smae_pkg::OP_STATUS: begin
        stat.ready  = out_free;
        emit_status = cmd.valid && out_free;
      end
      default: begin
        stat.ready = 1'b1;
      end
    endcase
    fire           = cmd.valid && stat.ready;
    stat.acc_valid = acc_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_valid <= 1'b0;
      o_valid   <= 1'b0;
    end else begin
      if (fire && (cmd.op == smae_pkg::OP_RUN) && !run_zero && !run_merge) begin
        acc_valid <= 1'b1;
      end else if (fire && (cmd.op == smae_pkg::OP_CLOSE)) begin
        acc_valid <= 1'b0;
      end
      if (emit_acc || emit_status) begin
        o_valid <= 1'b1;
      end else if (results.ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  // merge register and output beat
  always_ff @(posedge clk) begin
    if (fire && (cmd.op == smae_pkg::OP_RUN) && !run_zero) begin
      if (run_merge) begin
        acc_run <= run_sum[smae_pkg::RUN_W-1:0];
      end else begin
        acc_bit <= cmd.code_bit;
        acc_run <= cmd.count;
      end
    end
    if (emit_acc) begin
      o_bit    <= acc_bit;
      o_run    <= acc_run;
      o_status <= smae_pkg::ST_OK;
      o_last   <= (cmd.op == smae_pkg::OP_CLOSE) && cmd.last;
    end else if (emit_status) begin
      o_bit    <= 1'b0;
      o_run    <= '0;
      o_status <= cmd.status;
      o_last   <= cmd.last;
    end
  end

  assign results.valid      = o_valid;
  assign results.code_bit   = o_bit;
  assign results.run_length = o_run;
  assign results.status     = o_status;
  assign results.last       = o_last;

  `SMAE_ASSERT_NOW(a_acc_nonzero, acc_valid, acc_run != '0, "empty run held for merging")
  `SMAE_ASSERT_NOW(a_status_bare, o_valid && (o_status != smae_pkg::ST_OK), (o_run == '0) && !o_bit, "status beat carries bits")
  `SMAE_ASSERT_NOW(a_ok_nonempty, o_valid && (o_status == smae_pkg::ST_OK) && !o_last, o_run != '0, "empty run beat before the last")

endmodule

/* sv/static_model_arithmetic_encoder_core.sv */
// load: stays idle, writes one table entry if its index is in range, no result beats
// encode: accept, two reads on one table port, range update, the states CARRY1 and CARRY2
//   for a carry into pending ones, then the renormalization bits and released runs, then the
//   closing or status beats
// flush: accept, a walk over all base bits, released runs, then release and close
// one item at a time, result stalls hold the sequencer; rst (sync, active high) resets range
`include "static_model_arithmetic_encoder_core_assert.svh"

module static_model_arithmetic_encoder_core (
  input  logic       clk,
  input  logic       rst,
  smae_in_if.sink    items,
  smae_out_if.source results
);

  // sequencer states
  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_RD1      = 4'd1;
  localparam logic [3:0] S_RD2      = 4'd2;
  localparam logic [3:0] S_CALC     = 4'd3;
  localparam logic [3:0] S_CARRY1   = 4'd4;
  localparam logic [3:0] S_CARRY2   = 4'd5;
  localparam logic [3:0] S_RENORM   = 4'd6;
  localparam logic [3:0] S_DIG_ONES = 4'd7;
  localparam logic [3:0] S_REL_HELD = 4'd8;
  localparam logic [3:0] S_REL_ONES = 4'd9;
  localparam logic [3:0] S_FIN      = 4'd10;

  logic [3:0]                      state;

  // cumulative frequency table, one write port and one read port, registered read
  logic [smae_pkg::VALUE_W-1:0]    model_table [0:smae_pkg::TABLE_DEPTH-1];
  logic [smae_pkg::VALUE_W-1:0]    rd_data;
  logic [smae_pkg::INDEX_W-1:0]    rd_addr;
  logic                            load_we;
  logic                            accept;

  // coder state
  logic [smae_pkg::RANGE_W-1:0]    range_base;
  logic [smae_pkg::RANGE_W-1:0]    range_length;
  logic                            held_valid;
  logic                            held_bit;
  logic [smae_pkg::ONES_W-1:0]     ones;

  // per-item working registers
  logic [smae_pkg::SYMBOL_W-1:0]   sym;
  logic [smae_pkg::VALUE_W-1:0]    lo;
  logic [smae_pkg::VALUE_W-1:0]    hi;
  logic [smae_pkg::CNT_W-1:0]      cnt;
  logic                            flushing;
  logic                            zero_width;
  logic                            run_ovf;

  // datapath
  logic [smae_pkg::PROD_W-1:0]     prod;
  logic [smae_pkg::RANGE_W+1:0]    base_sum;
  logic [smae_pkg::VALUE_W-1:0]    len_diff;
  logic [smae_pkg::RANGE_W-1:0]    len_sat;
  logic                            carry;
  logic                            digit;
  logic                            loop_more;
  logic                            step;
  logic                            go;
  logic                            fin_last;

  smae_pkg::pack_cmd_t             cmd;
  smae_pkg::pack_stat_t            pk_stat;

  assign items.ready = (state == S_IDLE);
  assign accept      = items.valid && items.ready;
  assign load_we     = accept && (items.action == smae_pkg::ACT_LOAD) &&
                       (items.table_index <= smae_pkg::TABLE_LAST);

  // first read is the symbol's low bound, taken on the accept edge; then the upper bound
  assign rd_addr = (state == S_IDLE) ? {1'b0, items.symbol} :
                                       ({1'b0, sym} + smae_pkg::INDEX_W'(1));

  always_ff @(posedge clk) begin
    if (load_we) begin
      model_table[items.table_index] <= items.table_value;
    end
    rd_data <= model_table[rd_addr];
  end

  // one multiplier serves both bounds; its high part is registered as lo, then hi
  assign prod = {{smae_pkg::VALUE_W{1'b0}}, range_length} *
                {{smae_pkg::RANGE_W{1'b0}}, rd_data};

  always_comb begin
    base_sum  = {2'b00, range_base} + {1'b0, lo};
    len_diff  = hi - lo;
    len_sat   = len_diff[smae_pkg::VALUE_W-1] ? '1 : len_diff[smae_pkg::RANGE_W-1:0];
    carry     = |base_sum[smae_pkg::RANGE_W+1:smae_pkg::RANGE_W];
    digit     = range_base[smae_pkg::RANGE_W-1];
    // encode shifts until the range is at least half; flush walks every base bit
    loop_more = flushing ? (cnt != '0) : !range_length[smae_pkg::RANGE_W-1];
    fin_last  = !zero_width && !run_ovf;
  end

  // run and status requests toward the packer, at most one per cycle
  always_comb begin
    cmd = '0;
    unique case (state)
      S_CARRY1: begin
        // carry into a held zero: the held bit becomes one
        cmd.valid    = 1'b1;
        cmd.op       = smae_pkg::OP_RUN;
        cmd.code_bit = 1'b1;
        cmd.count    = smae_pkg::RUN_W'(1);
      end
      S_CARRY2: begin
        // ...and the pending ones become zeros; the last of them stays held as a zero
        cmd.valid    = 1'b1;
        cmd.op       = smae_pkg::OP_RUN;
        cmd.code_bit = 1'b0;
        cmd.count    = smae_pkg::RUN_W'(ones - smae_pkg::ONES_W'(1));
      end
      S_RENORM: begin
        // a zero digit releases the held bit and its pending ones
        cmd.valid    = loop_more && held_valid && !digit;
        cmd.op       = smae_pkg::OP_RUN;
        cmd.code_bit = held_bit;
        cmd.count    = smae_pkg::RUN_W'(1);
      end
      S_DIG_ONES, S_REL_ONES: begin
        cmd.valid    = 1'b1;
        cmd.op       = smae_pkg::OP_RUN;
        cmd.code_bit = 1'b1;
        cmd.count    = smae_pkg::RUN_W'(ones);
      end
      S_REL_HELD: begin
        cmd.valid    = held_valid;
        cmd.op       = smae_pkg::OP_RUN;
        cmd.code_bit = held_bit;
        cmd.count    = smae_pkg::RUN_W'(1);
      end
      S_FIN: begin
        // close the merged run, then zero-width, then overflow, else a bare ok beat
        cmd.valid = 1'b1;
        priority if (pk_stat.acc_valid) begin
          cmd.op   = smae_pkg::OP_CLOSE;
          cmd.last = fin_last;
        end else if (zero_width) begin
          cmd.op     = smae_pkg::OP_STATUS;
          cmd.status = smae_pkg::ST_ZERO_WIDTH;
          cmd.last   = !run_ovf;
        end else if (run_ovf) begin
          cmd.op     = smae_pkg::OP_STATUS;
          cmd.status = smae_pkg::ST_RUN_OVF;
          cmd.last   = 1'b1;
        end else begin
          cmd.op     = smae_pkg::OP_STATUS;
          cmd.status = smae_pkg::ST_OK;
          cmd.last   = 1'b1;
        end
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  assign go = !cmd.valid || pk_stat.ready;

  // one code digit consumed: shift the range
  assign step = ((state == S_RENORM) && loop_more && (!held_valid || digit)) ||
                ((state == S_DIG_ONES) && go);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      range_base   <= '0;
      range_length <= '1;
      held_valid   <= 1'b0;
      held_bit     <= 1'b0;
      ones         <= '0;
      flushing     <= 1'b0;
      zero_width   <= 1'b0;
      run_ovf      <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            zero_width <= 1'b0;
            run_ovf    <= 1'b0;
            unique case (items.action)
              smae_pkg::ACT_ENCODE: begin
                flushing <= 1'b0;
                if ({1'b0, items.symbol} < smae_pkg::SYMBOL_LIMIT) begin
                  state <= S_RD1;
                end else begin
                  zero_width <= 1'b1;
                  state      <= S_FIN;
                end
              end
              smae_pkg::ACT_FLUSH: begin
                flushing <= 1'b1;
                state    <= S_RENORM;
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_RD1: begin
          state <= S_RD2;
        end
        S_RD2: begin
          state <= S_CALC;
        end
        S_CALC: begin
          if (hi <= lo) begin
            // empty interval: symbol not coded, state kept
            zero_width <= 1'b1;
            state      <= S_FIN;
          end else begin
            range_base   <= base_sum[smae_pkg::RANGE_W-1:0];
            range_length <= len_sat;
            // a carry only lands on a held zero; otherwise it is dropped
            if (carry && held_valid && !held_bit) begin
              if (ones == '0) begin
                held_bit <= 1'b1;
                state    <= S_RENORM;
              end else begin
                state <= S_CARRY1;
              end
            end else begin
              state <= S_RENORM;
            end
          end
        end
        S_CARRY1: begin
          if (go) begin
            state <= S_CARRY2;
          end
        end
        S_CARRY2: begin
          if (go) begin
            held_bit <= 1'b0;
            ones     <= '0;
            state    <= S_RENORM;
          end
        end
        S_RENORM: begin
          if (!loop_more) begin
            state <= flushing ? S_REL_HELD : S_FIN;
          end else if (!held_valid) begin
            held_valid <= 1'b1;
            held_bit   <= digit;
            ones       <= '0;
          end else if (digit) begin
            // saturating pending-ones counter; a lost one is flagged
            if (ones != '1) begin
              ones <= ones + smae_pkg::ONES_W'(1);
            end else begin
              run_ovf <= 1'b1;
            end
          end else if (go) begin
            state <= S_DIG_ONES;
          end
          if (step) begin
            range_base   <= range_base << 1;
            range_length <= range_length << 1;
          end
        end
        S_DIG_ONES: begin
          if (go) begin
            held_valid   <= 1'b1;
            held_bit     <= 1'b0;
            ones         <= '0;
            range_base   <= range_base << 1;
            range_length <= range_length << 1;
            state        <= S_RENORM;
          end
        end
        S_REL_HELD: begin
          if (!held_valid) begin
            range_base   <= '0;
            range_length <= '1;
            state        <= S_FIN;
          end else if (go) begin
            state <= S_REL_ONES;
          end
        end
        S_REL_ONES: begin
          if (go) begin
            held_valid   <= 1'b0;
            held_bit     <= 1'b0;
            ones         <= '0;
            range_base   <= '0;
            range_length <= '1;
            state        <= S_FIN;
          end
        end
        S_FIN: begin
          if (go) begin
            priority if (pk_stat.acc_valid) begin
              if (fin_last) begin
                state <= S_IDLE;
              end
            end else if (zero_width) begin
              zero_width <= 1'b0;
              if (!run_ovf) begin
                state <= S_IDLE;
              end
            end else if (run_ovf) begin
              run_ovf <= 1'b0;
              state   <= S_IDLE;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // working registers without reset
  always_ff @(posedge clk) begin
    if (accept) begin
      sym <= items.symbol;
      cnt <= smae_pkg::FLUSH_COUNT;
    end else if (step) begin
      cnt <= cnt - smae_pkg::CNT_W'(1);
    end
    if (state == S_RD1) begin
      lo <= prod[smae_pkg::PROD_W-1:smae_pkg::RANGE_W];
    end
    if (state == S_RD2) begin
      hi <= prod[smae_pkg::PROD_W-1:smae_pkg::RANGE_W];
    end
  end

  // run merging and the output beat register
  smae_run_pack u_pack (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .stat    (pk_stat),
    .results (results)
  );

  `SMAE_ASSERT_NOW(a_hold_clear, !held_valid, ones == '0, "pending ones without a held bit")
  `SMAE_ASSERT_NOW(a_idle_norm, state == S_IDLE, range_length[smae_pkg::RANGE_W-1], "range not normalized at rest")
  `SMAE_ASSERT_NOW(a_accept_empty, accept, !pk_stat.acc_valid, "item accepted with a run still merging")
  `SMAE_ASSERT_NEXT(a_calc_order, state == S_RD2, state == S_CALC, "range update out of order")

endmodule

/* tb/sv/static_model_arithmetic_encoder_core_test.sv */
`timescale 1ns / 100ps

// pending ones and single runs both saturate here
localparam int RUN_CAP = (smae_pkg::RUN_BITS >= 16) ? 65535 : (1 << smae_pkg::RUN_BITS) - 1;
localparam int MAX_BEATS = 40;
localparam int RANGE_MASK = (1 << smae_pkg::PRECISION) - 1;
localparam int HALF_RANGE = 1 << (smae_pkg::PRECISION - 1);

typedef logic [smae_pkg::RANGE_W-1:0] range_t;
typedef logic [smae_pkg::VALUE_W-1:0] freq_t;

typedef struct packed {
  logic                          code_bit;
  logic [smae_pkg::RUN_W-1:0]    run_length;
  logic [smae_pkg::STATUS_W-1:0] status;
  logic                          last;
} run_beat_t;

class coder_scoreboard;
  freq_t       freq_table [0:smae_pkg::ALPHABET];
  range_t      code_base;
  range_t      code_span;
  bit          held_valid;
  bit          held_bit;
  int unsigned ones_held;
  bit          ones_overflow;
  run_beat_t   step_beats [$];
  run_beat_t   awaited_beats [$];
  int unsigned fail_count;

  function new();
    code_base  = '0;
    code_span  = range_t'(RANGE_MASK);
    held_valid = 1'b0;
    held_bit   = 1'b0;
    ones_held  = 0;
    fail_count = 0;
  endfunction

  // append a run of equal bits, merging into the previous run while it fits
  function void add_run(bit b, int unsigned n);
    run_beat_t   rb;
    int unsigned part;
    if (n == 0) return;
    if (step_beats.size() > 0) begin
      rb = step_beats[$];
      if (rb.status == smae_pkg::ST_OK && rb.code_bit == b &&
          int'(rb.run_length) + n <= 65535) begin
        rb.run_length = smae_pkg::RUN_W'(rb.run_length + n);
        void'(step_beats.pop_back());
        step_beats.push_back(rb);
        return;
      end
    end
    while (n > 0 && step_beats.size() < MAX_BEATS) begin
      part = (n > 65535) ? 65535 : n;
      rb = '{code_bit: b, run_length: smae_pkg::RUN_W'(part), status: smae_pkg::ST_OK,
             last: 1'b0};
      step_beats.push_back(rb);
      n -= part;
    end
  endfunction

  function void add_status(logic [smae_pkg::STATUS_W-1:0] st);
    if (step_beats.size() < MAX_BEATS)
      step_beats.push_back('{code_bit: 1'b0, run_length: '0, status: st, last: 1'b0});
  endfunction

  function void release_held();
    if (held_valid) begin
      add_run(held_bit, 1);
      add_run(1'b1, ones_held);
    end
    held_valid = 1'b0;
    held_bit   = 1'b0;
    ones_held  = 0;
  endfunction

  function void put_digit(bit d);
    if (!held_valid) begin
      held_valid = 1'b1;
      held_bit   = d;
      ones_held  = 0;
    end else if (d) begin
      if (ones_held < RUN_CAP) ones_held++;
      else ones_overflow = 1'b1;
    end else begin
      release_held();
      held_valid = 1'b1;
      held_bit   = 1'b0;
    end
  endfunction

  // a carry flips a held zero and its pending ones; anything else drops it
  function void apply_carry();
    if (!held_valid || held_bit) return;
    if (ones_held == 0) begin
      held_bit = 1'b1;
      return;
    end
    add_run(1'b1, 1);
    add_run(1'b0, ones_held - 1);
    held_bit  = 1'b0;
    ones_held = 0;
  endfunction

  // works out the result beats of one accepted input beat
  function void code_item(logic [smae_pkg::ACTION_W-1:0] action,
                          logic [smae_pkg::SYMBOL_W-1:0] symbol,
                          logic [smae_pkg::INDEX_W-1:0]  index,
                          freq_t                         value);
    logic [smae_pkg::PROD_W-1:0]    lo_prod;
    logic [smae_pkg::PROD_W-1:0]    hi_prod;
    freq_t                          lo;
    freq_t                          hi;
    freq_t                          new_span;
    logic [smae_pkg::RANGE_W+1:0]   sum;
    range_t                         next_base;
    bit                             zero_width;
    run_beat_t                      rb;
    int                             i;
    step_beats.delete();
    ones_overflow = 1'b0;
    zero_width    = 1'b0;
    case (action)
      smae_pkg::ACT_LOAD: begin
        if (index <= smae_pkg::ALPHABET) freq_table[index] = value;
        return;
      end
      smae_pkg::ACT_ENCODE: begin
        lo_prod = code_span;
        lo_prod = lo_prod * freq_table[symbol];
        hi_prod = code_span;
        hi_prod = hi_prod * freq_table[int'(symbol) + 1];
        lo = freq_t'(lo_prod >> smae_pkg::PRECISION);
        hi = freq_t'(hi_prod >> smae_pkg::PRECISION);
        if (hi <= lo) begin
          zero_width = 1'b1;
        end else begin
          sum       = code_base + lo;
          next_base = range_t'(sum);
          new_span  = hi - lo;
          if (new_span > RANGE_MASK) new_span = freq_t'(RANGE_MASK);
          if (sum > RANGE_MASK) apply_carry();
          while (new_span < HALF_RANGE) begin
            put_digit(next_base[smae_pkg::RANGE_W-1]);
            new_span  = new_span << 1;
            next_base = next_base << 1;
          end
          code_base = next_base;
          code_span = range_t'(new_span);
        end
      end
      smae_pkg::ACT_FLUSH: begin
        for (i = smae_pkg::PRECISION - 1; i >= 0; i--) put_digit(code_base[i]);
        release_held();
        code_base = '0;
        code_span = range_t'(RANGE_MASK);
      end
      default: return;
    endcase
    if (zero_width) add_status(smae_pkg::ST_ZERO_WIDTH);
    if (ones_overflow) add_status(smae_pkg::ST_RUN_OVF);
    if (step_beats.size() == 0) add_status(smae_pkg::ST_OK);
    rb = step_beats.pop_back();
    rb.last = 1'b1;
    step_beats.push_back(rb);
    foreach (step_beats[k]) awaited_beats.push_back(step_beats[k]);
  endfunction

  task report(string what);
    fail_count++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  task check_beat(run_beat_t got);
    run_beat_t want;
    if (awaited_beats.size() == 0) begin
      report($sformatf("beat with nothing awaited: bit %0d run %0d status %0d last %0d",
                       got.code_bit, got.run_length, got.status, got.last));
      return;
    end
    want = awaited_beats.pop_front();
    if (got.code_bit !== want.code_bit)
      report($sformatf("code_bit %0d, want %0d", got.code_bit, want.code_bit));
    if (got.run_length !== want.run_length)
      report($sformatf("run_length %0d, want %0d", got.run_length, want.run_length));
    if (got.status !== want.status)
      report($sformatf("status %0d, want %0d", got.status, want.status));
    if (got.last !== want.last)
      report($sformatf("last %0d, want %0d", got.last, want.last));
  endtask
endclass

module static_model_arithmetic_encoder_core_test;

  localparam int TIMEOUT_NS    = 10_000_000;
  localparam int SETTLE_CYCLES = 64;          // covers a flush plus its release beats
  localparam int IDLE_PCT      = 18;
  localparam int SEGMENT_ITEMS = 50;          // with the table load, about 380 items

  logic clk;
  logic rst;
  bit   calm;  // when set, neither side idles

  smae_in_if  items_if ();
  smae_out_if results_if ();

  coder_scoreboard sb;

  static_model_arithmetic_encoder_core u_dut (
    .clk     (clk),
    .rst     (rst),
    .items   (items_if.sink),
    .results (results_if.source)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result side back-pressure, changed on the falling edge
  always @(negedge clk) begin
    results_if.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
  end

  // every accepted result beat goes to the checker
  always @(posedge clk) begin
    if (!rst && results_if.valid && results_if.ready)
      sb.check_beat({results_if.code_bit, results_if.run_length,
                     results_if.status, results_if.last});
  end

  initial begin
    #(TIMEOUT_NS);
    $display("CHECKS FAILED");
    $finish;
  end

  // drive one input beat, with random gaps ahead of it, and hand it to the predictor
  task send_item(logic [smae_pkg::ACTION_W-1:0] action,
                 logic [smae_pkg::SYMBOL_W-1:0] symbol,
                 logic [smae_pkg::INDEX_W-1:0] index, freq_t value);
    @(negedge clk);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      items_if.valid <= 1'b0;
      @(negedge clk);
    end
    items_if.valid       <= 1'b1;
    items_if.action      <= action;
    items_if.symbol      <= symbol;
    items_if.table_index <= index;
    items_if.table_value <= value;
    @(posedge clk);
    while (!items_if.ready) @(posedge clk);
    sb.code_item(action, symbol, index, value);
  endtask

  // unused fields carry junk so the block is seen to ignore them
  task load(logic [smae_pkg::INDEX_W-1:0] index, freq_t value);
    send_item(smae_pkg::ACT_LOAD, smae_pkg::SYMBOL_W'($urandom_range(255)), index, value);
  endtask

  task encode(logic [smae_pkg::SYMBOL_W-1:0] symbol);
    send_item(smae_pkg::ACT_ENCODE, symbol, smae_pkg::INDEX_W'($urandom_range(511)),
              freq_t'($urandom_range(65536)));
  endtask

  task flush();
    send_item(smae_pkg::ACT_FLUSH, smae_pkg::SYMBOL_W'($urandom_range(255)),
              smae_pkg::INDEX_W'($urandom_range(511)), freq_t'($urandom_range(65536)));
  endtask

  // writes a whole exclusive cumulative table: 0 uniform, 1 random with holes,
  // 2 heavily skewed toward symbol 0
  task load_table(int shape);
    longint unsigned weight [256];
    longint unsigned total;
    longint unsigned prefix;
    int              s;
    total = 0;
    for (s = 0; s < 256; s++) begin
      case (shape)
        0: weight[s] = 1;
        1: weight[s] = ($urandom_range(3) == 0) ? 0 : $urandom_range(1000, 1);
        default: weight[s] = (s == 0) ? 60000 : $urandom_range(3);
      endcase
    end
    // never an all-zero table
    if (shape != 0) weight[$urandom_range(255)] += 1;
    foreach (weight[w]) total += weight[w];
    prefix = 0;
    for (s = 0; s <= smae_pkg::ALPHABET; s++) begin
      load(smae_pkg::INDEX_W'(s), freq_t'((prefix << smae_pkg::PRECISION) / total));
      if (s < smae_pkg::ALPHABET) prefix += weight[s];
    end
  endtask

  initial begin
    int seg;
    int count;
    int pick;
    int idx;
    sb = new();
    calm                 = 1'b0;
    rst                  = 1'b1;
    items_if.valid       = 1'b0;
    items_if.action      = smae_pkg::ACT_LOAD;
    items_if.symbol      = '0;
    items_if.table_index = '0;
    items_if.table_value = '0;
    results_if.ready     = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // every table entry is written before the first encode
    load_table(0);

    // loads past the end of the table are dropped
    load(9'd257, 17'd65536);
    load(9'd511, 17'd0);

    // symbol extremes and alternating bit patterns
    encode(8'd0);
    encode(8'd255);
    encode(8'd128);
    encode(8'hAA);
    encode(8'h55);
    flush();
    // flush straight after a flush: sixteen zero base bits
    flush();

    // zero-width interval: entry 11 equal to entry 10 kills symbol 10
    load(9'd11, sb.freq_table[10]);
    encode(8'd10);
    encode(8'd11);

    // oversized entry: symbol 200 gets a span past full scale and saturates,
    // symbol 201 then sees its upper bound below its lower one
    load(9'd201, 17'h1FFFF);
    encode(8'd200);
    encode(8'd201);
    load(9'd201, freq_t'(201 * 256));
    flush();

    // random segments, the first one with no idling on either side
    for (seg = 0; seg < 2; seg++) begin
      calm  = (seg == 0);
      count = 0;
      while (count < SEGMENT_ITEMS) begin
        pick = $urandom_range(99);
        if (pick < 66) begin
          encode(smae_pkg::SYMBOL_W'($urandom_range(255)));
        end else if (pick < 74) begin
          flush();
        end else if (pick < 86) begin
          // reload one inner entry between its neighbors, a monotonic table stays monotonic
          idx = $urandom_range(255, 1);
          load(smae_pkg::INDEX_W'(idx), freq_t'($urandom_range(sb.freq_table[idx - 1],
                                                                sb.freq_table[idx + 1])));
        end else if (pick < 92) begin
          // any entry, any value in range: breaks the ordering now and then
          load(smae_pkg::INDEX_W'($urandom_range(smae_pkg::ALPHABET)),
               freq_t'($urandom_range(65536)));
        end else begin
          load(smae_pkg::INDEX_W'($urandom_range(511, smae_pkg::ALPHABET + 1)),
               freq_t'($urandom_range(65536)));
          count--;  // ignored by the block
        end
        count++;
      end
    end
    calm = 1'b0;

    flush();

    @(negedge clk);
    items_if.valid <= 1'b0;

    while (sb.awaited_beats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (sb.fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+sv
sv/smae_pkg.sv
sv/smae_ifs.sv
sv/smae_run_pack.sv
sv/static_model_arithmetic_encoder_core.sv
tb/sv/static_model_arithmetic_encoder_core_test.sv
